// File: rtl/stl_pkg.sv
// Shared types and constants for the script token lexer.
// No dependencies.
`default_nettype none
package stl_pkg;
  localparam int PosBits = 16;
  localparam int KwLen = 8;
  localparam int MaxNest = 15;
  localparam int NestBits = 4;
  localparam int LenBits = 3;

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_WORD  = 3'd1;
  localparam logic [2:0] M_NUM   = 3'd2;
  localparam logic [2:0] M_STR   = 3'd3;
  localparam logic [2:0] M_EQ    = 3'd4;
  localparam logic [2:0] M_SLASH = 3'd5;
  localparam logic [2:0] M_BLOCK = 3'd6;
  localparam logic [2:0] M_LINE  = 3'd7;

  localparam logic [4:0] K_END   = 5'd0;
  localparam logic [4:0] K_IDENT = 5'd1;
  localparam logic [4:0] K_INT   = 5'd2;
  localparam logic [4:0] K_STR   = 5'd3;
  localparam logic [4:0] K_SLASH = 5'd6;
  localparam logic [4:0] K_ASSIGN = 5'd18;
  localparam logic [4:0] K_EQEQ  = 5'd19;
  localparam logic [4:0] K_ERROR = 5'd31;

  typedef struct packed {
    logic [4:0]         kind;
    logic [PosBits-1:0] start;
    logic [PosBits-1:0] len;
    logic [PosBits-1:0] line;
    logic [PosBits-1:0] col;
    logic               last;
  } token_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } item_t;

  function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] v);
    sat_inc = (v == {PosBits{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    logic [7:0] l;
    l = b | 8'h20;
    is_alpha = (l >= "a") && (l <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= "0") && (b <= "9");
  endfunction

  function automatic logic [4:0] punct_code(input logic [7:0] b);
    case (b)
      "+": punct_code = 5'd4;
      "-": punct_code = 5'd5;
      "*": punct_code = 5'd7;
      ":": punct_code = 5'd8;
      ";": punct_code = 5'd9;
      "(": punct_code = 5'd10;
      ")": punct_code = 5'd11;
      "[": punct_code = 5'd12;
      "]": punct_code = 5'd13;
      "{": punct_code = 5'd14;
      "}": punct_code = 5'd15;
      ".": punct_code = 5'd16;
      ",": punct_code = 5'd17;
      "<": punct_code = 5'd20;
      default: punct_code = K_ERROR;
    endcase
  endfunction

  function automatic logic [4:0] word_kind(input logic [KwLen*8-1:0] w,
                                           input logic [PosBits-1:0] n);
    word_kind = K_IDENT;
    case (n)
      16'd2: if (w[15:0] == "fi") word_kind = 5'd22;
      16'd3: if (w[23:0] == "rav") word_kind = 5'd21;
      16'd4: begin
        if (w[31:0] == "cnuf") word_kind = 5'd23;
        else if (w[31:0] == "eurt") word_kind = 5'd25;
      end
      16'd5: begin
        if (w[39:0] == "eslaf") word_kind = 5'd26;
        else if (w[39:0] == "ssalc") word_kind = 5'd27;
        else if (w[39:0] == "elihw") word_kind = 5'd28;
        else if (w[39:0] == "kaerb") word_kind = 5'd29;
      end
      16'd6: if (w[47:0] == "nruter") word_kind = 5'd24;
      16'd8: if (w[63:0] == "eunitnoc") word_kind = 5'd30;
      default: word_kind = K_IDENT;
    endcase
  endfunction
endpackage
`default_nettype wire

// File: rtl/stl_if.sv
// Valid/ready channels: stl_in_if carries a byte and end marker, stl_out_if carries token fields.
// No dependencies.
`default_nettype none
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_marker;
  modport source(output valid, char_byte, end_marker, input ready);
  modport sink(input valid, char_byte, end_marker, output ready);
endinterface

interface stl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic        last_of_run;
  modport source(output valid, token_kind, start_offset, token_length, line_number,
                 column_number, last_of_run, input ready);
  modport sink(input valid, token_kind, start_offset, token_length, line_number,
               column_number, last_of_run, output ready);
endinterface
`default_nettype wire

// File: rtl/stl_queue.sv
// Two-entry item queue between front and back parts.
// Depends on stl_pkg.
`default_nettype none
module stl_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire stl_pkg::item_t in_item,
  output logic               out_valid,
  input  wire logic          out_ready,
  output stl_pkg::item_t     out_item
);
  stl_pkg::item_t mem [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = mem[rp];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_item;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: rtl/stl_lexer.sv
// Back part: lexer state machine, emits up to two tokens per item via a two-slot output.
// Depends on stl_pkg.
`default_nettype none
module stl_lexer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire stl_pkg::item_t in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output stl_pkg::token_t     out_tok
);
  localparam int PB = stl_pkg::PosBits;
  localparam logic [PB-1:0] One = PB'(1);

  logic [2:0]     mode, mode_next;
  logic [7:0]     prev, prev_next;
  logic [stl_pkg::NestBits-1:0] nest, nest_next;
  logic [PB-1:0]  pos, pstart, plen, pline, pcol, lcnt, ccnt;
  logic [PB-1:0]  pstart_next, plen_next, pline_next, pcol_next;
  logic [7:0]     wbuf [stl_pkg::KwLen];
  logic [stl_pkg::KwLen*8-1:0] wflat;
  logic           wwr;
  logic [stl_pkg::LenBits-1:0] widx;

  // output slots: slot0 is shown, slot1 holds a second token
  stl_pkg::token_t slot0, slot1;
  logic v0, v1;

  stl_pkg::token_t t0, t1;
  logic e0, e1;
  logic [7:0] b;
  logic take;

  always_comb begin
    for (int i = 0; i < stl_pkg::KwLen; i++) wflat[i*8 +: 8] = wbuf[i];
  end

  assign out_valid = v0;
  assign out_tok = slot0;
  // accept when both slots will be free after this cycle
  assign in_ready = !v1 && (!v0 || out_ready);
  assign take = in_valid && in_ready;
  assign b = in_item.b;

  always_comb begin
    logic [4:0] pk;
    logic idle_go;
    logic [2:0] om;
    mode_next = mode;
    prev_next = prev;
    nest_next = nest;
    pstart_next = pstart;
    plen_next = plen;
    pline_next = pline;
    pcol_next = pcol;
    wwr = 1'b0;
    widx = '0;
    e0 = 1'b0;
    e1 = 1'b0;
    t0 = '0;
    t1 = '0;
    idle_go = 1'b0;
    om = stl_pkg::M_IDLE;
    pk = stl_pkg::K_IDENT;
    case (mode)
      stl_pkg::M_WORD: pk = stl_pkg::word_kind(wflat, plen);
      stl_pkg::M_NUM: pk = stl_pkg::K_INT;
      stl_pkg::M_STR: pk = stl_pkg::K_STR;
      stl_pkg::M_EQ: pk = stl_pkg::K_ASSIGN;
      stl_pkg::M_SLASH: pk = stl_pkg::K_SLASH;
      default: pk = stl_pkg::K_IDENT;
    endcase
    t0 = '{pk, pstart, plen, pline, pcol, 1'b0};
    if (in_item.eos) begin
      e0 = (mode != stl_pkg::M_IDLE) && (mode != stl_pkg::M_BLOCK)
           && (mode != stl_pkg::M_LINE);
      t1 = '{stl_pkg::K_END, pos, '0, lcnt, ccnt, 1'b0};
      e1 = 1'b1;
    end else begin
      case (mode)
        stl_pkg::M_WORD: begin
          if (stl_pkg::is_alpha(b) || stl_pkg::is_digit(b) || b == "_") begin
            if (plen < PB'(stl_pkg::KwLen)) begin
              wwr = 1'b1;
              widx = plen[stl_pkg::LenBits-1:0];
            end
            plen_next = stl_pkg::sat_inc(plen);
          end else begin
            e0 = 1'b1;
            idle_go = 1'b1;
          end
        end
        stl_pkg::M_NUM: begin
          if (stl_pkg::is_digit(b)) plen_next = stl_pkg::sat_inc(plen);
          else begin
            e0 = 1'b1;
            idle_go = 1'b1;
          end
        end
        stl_pkg::M_STR: begin
          plen_next = stl_pkg::sat_inc(plen);
          t0.len = plen_next;
          if (b == "\"" && prev != "\\") begin
            e0 = 1'b1;
            mode_next = stl_pkg::M_IDLE;
            prev_next = '0;
          end else if (b == "\\" && prev == "\\") prev_next = '0;
          else prev_next = b;
        end
        stl_pkg::M_EQ: begin
          if (b == "=") begin
            plen_next = PB'(2);
            t0.kind = stl_pkg::K_EQEQ;
            t0.len = PB'(2);
            e0 = 1'b1;
            mode_next = stl_pkg::M_IDLE;
          end else begin
            e0 = 1'b1;
            idle_go = 1'b1;
          end
        end
        stl_pkg::M_SLASH: begin
          if (b == "*") begin
            mode_next = stl_pkg::M_BLOCK;
            nest_next = stl_pkg::NestBits'(1);
            prev_next = '0;
          end else if (b == "/") mode_next = stl_pkg::M_LINE;
          else begin
            e0 = 1'b1;
            idle_go = 1'b1;
          end
        end
        stl_pkg::M_BLOCK: begin
          if (prev == "/" && b == "*") begin
            if (nest < stl_pkg::NestBits'(stl_pkg::MaxNest)) nest_next = nest + 1'b1;
            prev_next = '0;
          end else if (prev == "*" && b == "/") begin
            if (nest != '0) nest_next = nest - 1'b1;
            if (nest <= stl_pkg::NestBits'(1)) mode_next = stl_pkg::M_IDLE;
            prev_next = '0;
          end else prev_next = b;
        end
        stl_pkg::M_LINE: if (b == "\n") mode_next = stl_pkg::M_IDLE;
        default: idle_go = 1'b1;
      endcase
      if (idle_go) begin
        mode_next = stl_pkg::M_IDLE;
        om = stl_pkg::M_IDLE;
        if (b == "\n" || b == " " || b == "\t") om = stl_pkg::M_IDLE;
        else if (stl_pkg::is_alpha(b) || b == "_") begin
          om = stl_pkg::M_WORD;
          wwr = 1'b1;
          widx = '0;
        end else if (stl_pkg::is_digit(b)) om = stl_pkg::M_NUM;
        else if (b == "\"") begin
          om = stl_pkg::M_STR;
          prev_next = '0;
        end else if (b == "=") om = stl_pkg::M_EQ;
        else if (b == "/") om = stl_pkg::M_SLASH;
        else begin
          e1 = 1'b1;
          t1 = '{stl_pkg::punct_code(b), pos, One, lcnt, ccnt, 1'b0};
        end
        if (om != stl_pkg::M_IDLE) begin
          mode_next = om;
          pstart_next = pos;
          plen_next = One;
          pline_next = lcnt;
          pcol_next = ccnt;
        end
      end
    end
    if (e1) t1.last = 1'b1;
    else t0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (take && wwr) wbuf[widx] <= b;
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      mode <= stl_pkg::M_IDLE;
      prev <= '0;
      nest <= '0;
      pos <= '0;
      pstart <= '0;
      plen <= '0;
      pline <= One;
      pcol <= One;
      lcnt <= One;
      ccnt <= One;
    end else begin
      if (take) begin
        if (e0) begin
          slot0 <= t0;
          v0 <= 1'b1;
          slot1 <= t1;
          v1 <= e1;
        end else if (e1) begin
          slot0 <= t1;
          v0 <= 1'b1;
        end else if (v0 && out_ready) v0 <= 1'b0;
        if (in_item.eos) begin
          mode <= stl_pkg::M_IDLE;
          prev <= '0;
          nest <= '0;
          pos <= '0;
          pstart <= '0;
          plen <= '0;
          pline <= One;
          pcol <= One;
          lcnt <= One;
          ccnt <= One;
        end else begin
          mode <= mode_next;
          prev <= prev_next;
          nest <= nest_next;
          pstart <= pstart_next;
          plen <= plen_next;
          pline <= pline_next;
          pcol <= pcol_next;
          pos <= stl_pkg::sat_inc(pos);
          if (b == "\n") begin
            lcnt <= stl_pkg::sat_inc(lcnt);
            ccnt <= One;
          end else ccnt <= stl_pkg::sat_inc(ccnt);
        end
      end else if (v0 && out_ready) begin
        if (v1) begin
          slot0 <= slot1;
          v1 <= 1'b0;
        end else v0 <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/script_token_lexer.sv
// Script token lexer top level: input queue feeding the lexer core.
// An accepted byte is registered in the queue, then its tokens in the lexer output slots.
// Throughput: one byte per cycle if token_out is ready; input waits while slot1 is full.
// Reset (rst, synchronous): queue emptied, lexer state to idle, line and column to 1.
// Depends on stl_pkg, stl_if, stl_queue, stl_lexer.
`default_nettype none
module script_token_lexer (
  input wire logic     clk,
  input wire logic     rst,
  stl_in_if.sink       char_in,
  stl_out_if.source    token_out
);
  stl_pkg::item_t  qi, qo;
  logic            qv, qr;
  stl_pkg::token_t tok;

  assign qi = '{char_in.char_byte, char_in.end_marker};

  stl_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(char_in.valid), .in_ready(char_in.ready), .in_item(qi),
    .out_valid(qv), .out_ready(qr), .out_item(qo)
  );

  stl_lexer u_lexer (
    .clk(clk), .rst(rst),
    .in_valid(qv), .in_ready(qr), .in_item(qo),
    .out_valid(token_out.valid), .out_ready(token_out.ready), .out_tok(tok)
  );

  assign token_out.token_kind    = tok.kind;
  assign token_out.start_offset  = tok.start;
  assign token_out.token_length  = tok.len;
  assign token_out.line_number   = tok.line;
  assign token_out.column_number = tok.col;
  assign token_out.last_of_run   = tok.last;
endmodule
`default_nettype wire
